>>> rtl/core/xrr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the xorshift range random block.
// No dependencies.
package xrr_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SPAN_W  = 31;
    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;

    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] SEED_ONE = 32'h0000_0001;

    localparam logic CMD_RAW    = 1'b0;
    localparam logic CMD_RANGED = 1'b1;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [SPAN_W-1:0] divisor;
    } t_div_req;

endpackage

>>> rtl/core/xrr_gen.sv
`timescale 1ns / 1ps
// Xorshift32 generator state register (shifts 13, 17, 5) with seed load.
// Depends on xrr_pkg.
module xrr_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [xrr_pkg::WORD_W-1:0]  i_seed,
    input  logic                        i_step,
    output logic [xrr_pkg::WORD_W-1:0]  o_state
);

    logic [xrr_pkg::WORD_W-1:0] r_state;
    logic [xrr_pkg::WORD_W-1:0] n_state;
    logic [xrr_pkg::WORD_W-1:0] w_x1;
    logic [xrr_pkg::WORD_W-1:0] w_x2;
    logic [xrr_pkg::WORD_W-1:0] w_x3;

    always_comb begin
        w_x1 = r_state ^ (r_state << xrr_pkg::SHIFT_A);
        w_x2 = w_x1 ^ (w_x1 >> xrr_pkg::SHIFT_B);
        w_x3 = w_x2 ^ (w_x2 << xrr_pkg::SHIFT_C);
        n_state = r_state;
        if (i_seed_we) begin
            n_state = (i_seed == '0) ? xrr_pkg::SEED_ONE : i_seed;
        end else if (i_step) begin
            n_state = w_x3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xrr_pkg::SEED_ONE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

>>> rtl/core/xrr_mod.sv
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: 32-bit dividend, 31-bit divisor,
// one quotient bit per cycle. Depends on xrr_pkg.
module xrr_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  xrr_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [xrr_pkg::SPAN_W-1:0]  o_rem
);

    localparam int unsigned CNT_W = $clog2(xrr_pkg::WORD_W);

    logic                        r_busy;
    logic                        n_busy;
    logic                        r_done;
    logic                        n_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            n_cnt;
    logic [xrr_pkg::WORD_W-1:0]  r_dvd;
    logic [xrr_pkg::WORD_W-1:0]  n_dvd;
    logic [xrr_pkg::SPAN_W-1:0]  r_rem;
    logic [xrr_pkg::SPAN_W-1:0]  n_rem;
    logic [xrr_pkg::SPAN_W-1:0]  r_div;
    logic [xrr_pkg::SPAN_W-1:0]  n_div;
    logic [xrr_pkg::SPAN_W:0]    w_trial;
    logic [xrr_pkg::SPAN_W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_dvd[xrr_pkg::WORD_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = (w_trial >= {1'b0, r_div}) ? w_diff[xrr_pkg::SPAN_W-1:0]
                                               : w_trial[xrr_pkg::SPAN_W-1:0];
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(xrr_pkg::WORD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/xorshift_range_random_top.sv
`timescale 1ns / 1ps
// Top level of the xorshift range random block: sequencer and stream ports.
// Depends on xrr_pkg, xrr_gen and xrr_mod.
//
// One request beat in, one result beat out. A raw draw (tuser 0) returns the
// next xorshift32 word. A ranged draw (tuser 1) returns low + (word mod span)
// with span = high - low + 1; it runs the shared bit-serial remainder unit
// twice, once for the rejection limit and once for the final remainder, and
// redraws the generator for each word at or above the limit. A span outside
// 1 to 2^31-1 returns 0 with the error flag set and leaves the generator
// untouched. One request is in work at a time; the result sits in an output
// register so the next request is taken while it waits. Write the seed only
// while the block is idle.
module xorshift_range_random_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_seed_we,
    input  logic [31:0]  i_seed_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // low_bound [31:0], high_bound [63:32]
    input  logic         s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // value
    output logic         m_axis_tuser    // range_error
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SPAN = 3'd1;
    localparam logic [2:0] ST_LIM  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_MODX = 3'd4;
    localparam logic [2:0] ST_RAW  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam int unsigned W  = xrr_pkg::WORD_W;
    localparam int unsigned SW = xrr_pkg::SPAN_W;

    logic [2:0]    r_st;
    logic [2:0]    n_st;
    logic          r_cmd;
    logic          n_cmd;
    logic [W-1:0]  r_lo;
    logic [W-1:0]  n_lo;
    logic [W-1:0]  r_hi;
    logic [W-1:0]  n_hi;
    logic [SW-1:0] r_span;
    logic [SW-1:0] n_span;
    logic [W-1:0]  r_limit;
    logic [W-1:0]  n_limit;
    logic [W-1:0]  r_res;
    logic [W-1:0]  n_res;
    logic          r_err;
    logic          n_err;
    logic          r_ovld;
    logic          n_ovld;
    logic [W-1:0]  r_odata;
    logic [W-1:0]  n_odata;
    logic          r_oerr;
    logic          n_oerr;

    logic          w_step;
    logic [W-1:0]  w_gen;
    logic          w_div_done;
    logic [SW-1:0] w_rem;
    logic [W+1:0]  w_diff;
    logic          w_span_ok;
    logic          w_accept;
    xrr_pkg::t_div_req w_req;

    xrr_gen u_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_we (i_seed_we),
        .i_seed    (i_seed_wdata),
        .i_step    (w_step),
        .o_state   (w_gen)
    );

    xrr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    assign s_axis_tready = (r_st == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_diff    = {{2{r_hi[W-1]}}, r_hi} - {{2{r_lo[W-1]}}, r_lo} + (W+2)'(1);
        w_span_ok = (w_diff[W+1:SW] == '0) && (w_diff[SW-1:0] != '0);
    end

    always_comb begin
        n_st     = r_st;
        n_cmd    = r_cmd;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_span   = r_span;
        n_limit  = r_limit;
        n_res    = r_res;
        n_err    = r_err;
        n_ovld   = r_ovld;
        n_odata  = r_odata;
        n_oerr   = r_oerr;
        w_step   = 1'b0;
        w_req    = '{start: 1'b0, dividend: xrr_pkg::ALL_ONES, divisor: r_span};

        if (r_ovld && m_axis_tready) begin
            n_ovld = 1'b0;
        end

        case (r_st)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd = s_axis_tuser;
                    n_lo  = s_axis_tdata[W-1:0];
                    n_hi  = s_axis_tdata[2*W-1:W];
                    n_st  = ST_SPAN;
                end
            end
            ST_SPAN: begin
                if (r_cmd == xrr_pkg::CMD_RAW) begin
                    w_step = 1'b1;
                    n_st   = ST_RAW;
                end else if (!w_span_ok) begin
                    n_res = '0;
                    n_err = 1'b1;
                    n_st  = ST_OUT;
                end else begin
                    n_span = w_diff[SW-1:0];
                    w_req  = '{start: 1'b1, dividend: xrr_pkg::ALL_ONES,
                               divisor: w_diff[SW-1:0]};
                    n_st   = ST_LIM;
                end
            end
            ST_LIM: begin
                if (w_div_done) begin
                    n_limit = xrr_pkg::ALL_ONES - {1'b0, w_rem};
                    w_step  = 1'b1;
                    n_st    = ST_CHK;
                end
            end
            ST_CHK: begin
                if (w_gen >= r_limit) begin
                    w_step = 1'b1;
                end else begin
                    w_req = '{start: 1'b1, dividend: w_gen, divisor: r_span};
                    n_st  = ST_MODX;
                end
            end
            ST_MODX: begin
                if (w_div_done) begin
                    n_res = r_lo + {1'b0, w_rem};
                    n_err = 1'b0;
                    n_st  = ST_OUT;
                end
            end
            ST_RAW: begin
                n_res = w_gen;
                n_err = 1'b0;
                n_st  = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovld || m_axis_tready) begin
                    n_ovld  = 1'b1;
                    n_odata = r_res;
                    n_oerr  = r_err;
                    n_st    = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_ovld <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_span  <= n_span;
        r_limit <= n_limit;
        r_res   <= n_res;
        r_err   <= n_err;
        r_odata <= n_odata;
        r_oerr  <= n_oerr;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oerr;

endmodule
